// ----- hdl/pip_pkg.sv -----
// Shared constants and types for the point-in-polygon crossings core.
package pip_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_WIDTH_DEF  = 16;

    localparam int INDEX_W    = 6;
    localparam int COUNT_W    = 7;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [APB_ADDR_W-3:0] REG_VERTEX_COUNT = 1'b0;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef struct packed {
        logic clear;
        logic valid;
        logic head;
        logic room;
    } edge_ctl_t;

endpackage

// ----- hdl/pip_cell.sv -----
// One vertex cell of the rotating vertex ring.
module pip_cell #(
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              load_en,
    input  logic [DATA_W-1:0] load_data,
    input  logic              shift_en,
    input  logic [DATA_W-1:0] shift_data,
    output logic [DATA_W-1:0] data
);

    logic [DATA_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            data_reg <= load_data;
        end
        else if (shift_en)
        begin
            data_reg <= shift_data;
        end
    end

    assign data = data_reg;

endmodule

// ----- hdl/pip_edge.sv -----
// Edge walker and crossing unit: subpolygon tracking, exact product compare, parity.
module pip_edge
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  edge_ctl_t                     ctl,
    input  logic signed [COORD_WIDTH-1:0] vx,
    input  logic signed [COORD_WIDTH-1:0] vy,
    input  logic signed [COORD_WIDTH-1:0] tx,
    input  logic signed [COORD_WIDTH-1:0] ty,
    output logic                          parity
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic signed [COORD_WIDTH-1:0] x0_reg;
    logic signed [COORD_WIDTH-1:0] y0_reg;
    logic signed [COORD_WIDTH-1:0] fx_reg;
    logic signed [COORD_WIDTH-1:0] fy_reg;
    logic                          f0_reg;
    logic                          restart_reg;

    logic                 s1_valid_reg;
    logic                 s1_f1_reg;
    logic signed [DW-1:0] a_reg;
    logic signed [DW-1:0] b_reg;
    logic signed [DW-1:0] c_reg;
    logic signed [DW-1:0] d_reg;

    logic                 s2_valid_reg;
    logic                 s2_f1_reg;
    logic signed [PW-1:0] pl_reg;
    logic signed [PW-1:0] pr_reg;

    logic parity_reg;

    logic                 f1;
    logic                 start_vtx;
    logic                 edge_go;
    logic                 skip;
    logic                 ge;
    logic signed [DW-1:0] a_next;
    logic signed [DW-1:0] b_next;
    logic signed [DW-1:0] c_next;
    logic signed [DW-1:0] d_next;
    logic signed [PW-1:0] pl_next;
    logic signed [PW-1:0] pr_next;

    always_comb
    begin
        f1        = (vy >= ty);
        start_vtx = ctl.head || restart_reg;
        edge_go   = ctl.valid && !start_vtx && (f0_reg != f1);
        skip      = ctl.room && (vx == fx_reg) && (vy == fy_reg);
        a_next    = {vy[COORD_WIDTH-1], vy} - {ty[COORD_WIDTH-1], ty};
        b_next    = {x0_reg[COORD_WIDTH-1], x0_reg} - {vx[COORD_WIDTH-1], vx};
        c_next    = {vx[COORD_WIDTH-1], vx} - {tx[COORD_WIDTH-1], tx};
        d_next    = {y0_reg[COORD_WIDTH-1], y0_reg} - {vy[COORD_WIDTH-1], vy};
        pl_next   = a_reg * b_reg;
        pr_next   = c_reg * d_reg;
        ge        = (pl_reg >= pr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            parity_reg   <= 1'b0;
        end
        else if (ctl.clear)
        begin
            restart_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            parity_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.valid)
            begin
                restart_reg <= !start_vtx && skip;
            end
            s1_valid_reg <= edge_go;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg && (ge == s2_f1_reg))
            begin
                parity_reg <= !parity_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            if (start_vtx)
            begin
                x0_reg <= vx;
                y0_reg <= vy;
                fx_reg <= vx;
                fy_reg <= vy;
                f0_reg <= f1;
            end
            else if (!skip)
            begin
                x0_reg <= vx;
                y0_reg <= vy;
                f0_reg <= f1;
            end
        end
        s1_f1_reg <= f1;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        s2_f1_reg <= s1_f1_reg;
        pl_reg    <= pl_next;
        pr_reg    <= pr_next;
    end

    assign parity = parity_reg;

endmodule

// ----- hdl/point_in_polygon_crossings_core.sv -----
// done rises after a test transfer once the ring has made one pass and the crossing pipeline
// has drained through ST_DRAIN; a load is written straight into the addressed vertex cell.
// Tests do not overlap: busy holds from a test transfer until done, while the vertex ring rotates
// once past the crossing unit, one vertex per cycle; loads are taken every cycle while idle.
// done strobes for one cycle with inside_res; the receiver cannot stall.
// Reset clears the control state and vertex_count; vertex cells are undefined until loaded.
module point_in_polygon_crossings_core
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic [INDEX_W-1:0]            vertex_index,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    output logic                          done,
    output logic                          inside_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready
);

    localparam int DATA_W = 2 * COORD_WIDTH;
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } state_t;

    state_t                        state_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              n_reg;
    logic [1:0]                    drain_reg;
    logic                          done_reg;
    logic                          inside_res_reg;
    logic signed [COORD_WIDTH-1:0] tx_reg;
    logic signed [COORD_WIDTH-1:0] ty_reg;
    logic [COUNT_W-1:0]            count_reg;

    logic              load_go;
    logic              test_go;
    logic              cfg_sel;
    logic [CNT_W-1:0]  n_next;
    logic [DATA_W-1:0] ring_q [MAX_VERTICES];
    logic              parity;
    edge_ctl_t         ctl;

    assign busy    = (state_reg != ST_IDLE);
    assign load_go = start && !busy && (op == OP_LOAD);
    assign test_go = start && !busy && (op == OP_TEST);
    assign cfg_sel = (paddr[APB_ADDR_W-1:2] == REG_VERTEX_COUNT);
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? APB_DATA_W'(count_reg) : '0;

    always_comb
    begin
        if (int'(count_reg) > MAX_VERTICES)
        begin
            n_next = CNT_W'(MAX_VERTICES);
        end
        else
        begin
            n_next = CNT_W'(count_reg);
        end
        ctl.clear = test_go;
        ctl.valid = (state_reg == ST_WALK) && (cnt_reg < n_reg);
        ctl.head  = (cnt_reg == '0);
        ctl.room  = ((CNT_W+1)'(cnt_reg) + (CNT_W+1)'(2)) < (CNT_W+1)'(n_reg);
    end

    genvar g;
    generate
        for (g = 0; g < MAX_VERTICES; g++)
        begin : g_ring
            pip_cell #(
                .DATA_W(DATA_W)
            ) u_cell (
                .clk       (clk),
                .load_en   (load_go && (int'(vertex_index) == g)),
                .load_data ({coord_y, coord_x}),
                .shift_en  (state_reg == ST_WALK),
                .shift_data(ring_q[(g + 1) % MAX_VERTICES]),
                .data      (ring_q[g])
            );
        end
    endgenerate

    pip_edge #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .vx    (ring_q[0][COORD_WIDTH-1:0]),
        .vy    (ring_q[0][DATA_W-1:COORD_WIDTH]),
        .tx    (tx_reg),
        .ty    (ty_reg),
        .parity(parity)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && cfg_sel)
        begin
            count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            n_reg          <= '0;
            drain_reg      <= '0;
            done_reg       <= 1'b0;
            inside_res_reg <= 1'b0;
            tx_reg         <= '0;
            ty_reg         <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (test_go)
                    begin
                        state_reg <= ST_WALK;
                        cnt_reg   <= '0;
                        n_reg     <= n_next;
                        tx_reg    <= coord_x;
                        ty_reg    <= coord_y;
                    end
                end
                ST_WALK:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(MAX_VERTICES - 1))
                    begin
                        state_reg <= ST_DRAIN;
                        drain_reg <= '0;
                    end
                end
                ST_DRAIN:
                begin
                    drain_reg <= drain_reg + 1'b1;
                    if (drain_reg == 2'd2)
                    begin
                        state_reg      <= ST_IDLE;
                        done_reg       <= 1'b1;
                        inside_res_reg <= parity;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign inside_res = inside_res_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE) && $past(state_reg == ST_DRAIN))
        else $error("result outside drain exit");

    a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
        test_go |=> (state_reg == ST_WALK) && (cnt_reg == '0))
        else $error("test transfer did not start a walk");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (cnt_reg < CNT_W'(MAX_VERTICES)))
        else $error("walk counter past ring length");

    a_count_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (n_reg <= CNT_W'(MAX_VERTICES)))
        else $error("edge count above ring length");

endmodule
